FILE: design/stb_pkg.sv
package stb_pkg;

    localparam int SLOT_COUNT_DEF  = 32;
    localparam int COUNT_WIDTH_DEF = 32;
    localparam int MAX_RESULTS     = 32;
    localparam int RESULT_CNT_W    = $clog2(MAX_RESULTS + 1);

    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_START = 2'd1;
    localparam logic [1:0] MODE_STOP  = 2'd2;

    typedef struct packed {
        logic [1:0]         mode;
        logic [4:0]         slot;
        logic signed [31:0] period_value;
    } in_item_t;

    typedef struct packed {
        logic [4:0] expired_slot;
        logic       last_of_run;
    } out_item_t;

    typedef struct packed {
        logic shift;
        logic load;
        logic stop;
    } cell_ctrl_t;

    function automatic logic [31:0] abs_value(input logic [31:0] v);
        logic [31:0] r;
        r = v[31] ? (32'd0 - v) : v;
        return r;
    endfunction

endpackage

FILE: design/stb_sat_mag.sv
module stb_sat_mag #(
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  logic [31:0]            value,
    output logic [COUNT_WIDTH-2:0] mag
);

    localparam int CNT_W = COUNT_WIDTH - 1;
    localparam int EXT_W = (CNT_W > 32) ? CNT_W : 32;

    logic [EXT_W-1:0] abs_ext;
    logic [EXT_W-1:0] max_ext;
    logic [EXT_W-1:0] sat_ext;

    assign abs_ext = EXT_W'(stb_pkg::abs_value(value));
    assign max_ext = EXT_W'({CNT_W{1'b1}});
    assign sat_ext = (abs_ext > max_ext) ? max_ext : abs_ext;
    assign mag     = sat_ext[CNT_W-1:0];

endmodule

FILE: design/stb_cell.sv
module stb_cell #(
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  stb_pkg::cell_ctrl_t    ctrl,
    input  logic [31:0]            reload_in,
    input  logic [COUNT_WIDTH-2:0] count_in,
    input  logic [31:0]            load_value,
    input  logic [COUNT_WIDTH-2:0] load_count,
    output logic [31:0]            reload_out,
    output logic [COUNT_WIDTH-2:0] count_out
);

    logic [31:0]            reload_reg;
    logic [COUNT_WIDTH-2:0] count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= '0;
            count_reg  <= '0;
        end else if (ctrl.shift) begin
            reload_reg <= reload_in;
            count_reg  <= count_in;
        end else if (ctrl.load) begin
            reload_reg <= load_value;
            count_reg  <= load_count;
        end else if (ctrl.stop) begin
            reload_reg <= '0;
        end
    end

    assign reload_out = reload_reg;
    assign count_out  = count_reg;

endmodule

FILE: design/stb_slot_update.sv
module stb_slot_update #(
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  logic [31:0]            reload_cur,
    input  logic [COUNT_WIDTH-2:0] count_cur,
    output logic                   fire,
    output logic [31:0]            reload_new,
    output logic [COUNT_WIDTH-2:0] count_new
);

    localparam int CNT_W = COUNT_WIDTH - 1;

    logic [CNT_W-1:0] reload_mag;

    stb_sat_mag #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_mag (
        .value(reload_cur),
        .mag  (reload_mag)
    );

    always_comb begin
        fire       = 1'b0;
        reload_new = reload_cur;
        count_new  = count_cur;
        if (reload_cur != 32'd0) begin
            if (count_cur != '0) begin
                count_new = count_cur - CNT_W'(1);
            end else begin
                fire = 1'b1;
                if (reload_cur[31]) begin
                    count_new = reload_mag;
                end else begin
                    reload_new = 32'd0;
                    count_new  = '0;
                end
            end
        end
    end

endmodule

FILE: design/software_timer_bank_top.sv
// Start and stop: taken whenever the bank is idle; no result.
// Tick: the slot ring rotates once through the update cell, one slot per cycle
// while the result side does not stall.
// A result leaves one firing slot after it is found; the last one after the walk.
// Reset (synchronous, aresetn low) stops every slot at once; no clearing pass.
module software_timer_bank_top #(
    parameter int SLOT_COUNT  = stb_pkg::SLOT_COUNT_DEF,
    parameter int COUNT_WIDTH = stb_pkg::COUNT_WIDTH_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  stb_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output stb_pkg::out_item_t m_item
);

    localparam int CNT_W = COUNT_WIDTH - 1;
    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int NW    = stb_pkg::RESULT_CNT_W;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_WALK = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [NW-1:0]    n_reg, n_next;
    logic             pend_valid_reg, pend_valid_next;
    logic [4:0]       pend_slot_reg, pend_slot_next;
    logic             m_valid_reg, m_valid_next;
    stb_pkg::out_item_t m_item_reg, m_item_next;

    logic [31:0]      reload_q [SLOT_COUNT];
    logic [CNT_W-1:0] count_q  [SLOT_COUNT];
    logic [CNT_W-1:0] start_count;
    logic             head_fire;
    logic [31:0]      head_reload;
    logic [CNT_W-1:0] head_count;
    logic             s_accept, report, advance, out_free, shift_en;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign report   = head_fire && (n_reg < NW'(stb_pkg::MAX_RESULTS));
    assign advance  = !(report && pend_valid_reg && !out_free);
    assign shift_en = (state_reg == ST_WALK) && advance;

    stb_sat_mag #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_start_mag (
        .value(s_item.period_value),
        .mag  (start_count)
    );

    stb_slot_update #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_update (
        .reload_cur(reload_q[0]),
        .count_cur (count_q[0]),
        .fire      (head_fire),
        .reload_new(head_reload),
        .count_new (head_count)
    );

    for (genvar i = 0; i < SLOT_COUNT; i++) begin : g_ring
        stb_pkg::cell_ctrl_t ctrl;
        logic [31:0]         reload_in;
        logic [CNT_W-1:0]    count_in;

        assign ctrl.shift = shift_en;
        assign ctrl.load  = s_accept && (s_item.mode == stb_pkg::MODE_START)
                            && (int'(s_item.slot) == i);
        assign ctrl.stop  = s_accept && (s_item.mode == stb_pkg::MODE_STOP)
                            && (int'(s_item.slot) == i);

        if (i == SLOT_COUNT - 1) begin : g_tail
            assign reload_in = head_reload;
            assign count_in  = head_count;
        end else begin : g_link
            assign reload_in = reload_q[i+1];
            assign count_in  = count_q[i+1];
        end

        stb_cell #(
            .COUNT_WIDTH(COUNT_WIDTH)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .ctrl      (ctrl),
            .reload_in (reload_in),
            .count_in  (count_in),
            .load_value(s_item.period_value),
            .load_count(start_count),
            .reload_out(reload_q[i]),
            .count_out (count_q[i])
        );
    end

    always_comb begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        n_next          = n_reg;
        pend_valid_next = pend_valid_reg;
        pend_slot_next  = pend_slot_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_item_next     = m_item_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_item.mode == stb_pkg::MODE_TICK)) begin
                    state_next      = ST_WALK;
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_WALK: begin
                if (advance) begin
                    if (report) begin
                        if (pend_valid_reg) begin
                            m_valid_next             = 1'b1;
                            m_item_next.expired_slot = pend_slot_reg;
                            m_item_next.last_of_run  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_slot_next  = 5'(idx_reg);
                        n_next          = n_reg + NW'(1);
                    end
                    idx_next = idx_reg + IDX_W'(1);
                    if (idx_reg == IDX_W'(SLOT_COUNT - 1)) begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_FIN: begin
                if (!pend_valid_reg) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next             = 1'b1;
                    m_item_next.expired_slot = pend_slot_reg;
                    m_item_next.last_of_run  = 1'b1;
                    pend_valid_next          = 1'b0;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            n_reg          <= '0;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_slot_reg <= pend_slot_next;
        m_item_reg    <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

    a_result_only_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid_reg && (state_reg == ST_IDLE)) |=> !m_valid_reg)
        else $error("result appeared outside a tick walk");

    a_idle_no_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !pend_valid_reg)
        else $error("pending result left behind after a tick");

    a_report_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= NW'(stb_pkg::MAX_RESULTS))
        else $error("result count exceeds limit");

    a_walk_shift_holds_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_WALK) && !advance) |=> $stable(idx_reg))
        else $error("walk advanced while stalled");

endmodule
